// ===== design/assert_macros.svh =====
// assertion macros shared by the search locator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cts_pkg.sv =====
// types, constants and helpers for the caseless text search locator
`timescale 1ns / 1ps

package cts_pkg;

   localparam logic [7:0]  CH_CR     = 8'd13;
   localparam logic [7:0]  CH_LF     = 8'd10;
   localparam logic [7:0]  CASE_GAP  = 8'd32;
   localparam logic [7:0]  CHAR_A    = 8'h61;
   localparam logic [7:0]  CHAR_Z    = 8'h7a;
   localparam int          REG_BYTES = 16;
   localparam logic [15:0] COL_SAT   = 16'hffff;

   typedef enum logic [1:0] {
      CSR_PAT_LOW      = 2'd0,
      CSR_PAT_HIGH     = 2'd1,
      CSR_PAT_LEN      = 2'd2,
      CSR_SEARCH_START = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [11:0] line;
      logic [15:0] column;
   } position_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic [11:0] line;
      logic [15:0] column;
   } cell_word_type;

   typedef struct packed {
      logic        found;
      logic [15:0] match_offset;
      logic [11:0] match_line;
      logic [15:0] match_column;
   } rsp_word_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= CHAR_A && c <= CHAR_Z) begin
         return c - CASE_GAP;
      end
      return c;
   endfunction

endpackage

// ===== design/cts_cell.sv =====
// one window cell: holds a folded byte with its line and column, compares on shift-in
`timescale 1ns / 1ps

module cts_cell import cts_pkg::*; (
   input  logic          clock,
   input  logic          shift_en,
   input  cell_word_type in_word,
   input  logic          active,
   input  logic [7:0]    expected,
   output cell_word_type out_word,
   output logic          hit
);

   cell_word_type word_ff;
   cell_word_type word_in;

   always_comb begin
      word_in = shift_en ? in_word : word_ff;
      // compare what this cell holds after the shift
      hit = !active || (in_word.text_byte == expected);
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_word = word_ff;

endmodule

// ===== design/cts_position.sv =====
// line and column tracker with cr, lf and cr lf line breaks
`timescale 1ns / 1ps

module cts_position import cts_pkg::*; #(
   parameter int LINES_MAX = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         first,
   input  logic         clear,
   input  logic [7:0]   text_byte,
   output position_type position
);

   localparam int LINE_W = ($clog2(LINES_MAX) > 12) ? $clog2(LINES_MAX) : 12;
   localparam logic [LINE_W-1:0] LINE_CAP = LINE_W'(LINES_MAX - 1);

   logic [LINE_W-1:0] line_ff, line_in;
   logic [15:0]       column_ff, column_in;
   logic              cr_ff, lf_ff;
   logic              new_line;

   always_comb begin
      new_line  = (cr_ff && text_byte != CH_LF) || (lf_ff && !cr_ff);
      line_in   = line_ff;
      column_in = column_ff;
      if (!first) begin
         if (new_line && line_ff < LINE_CAP) begin
            line_in   = line_ff + 1'b1;
            column_in = '0;
         end else if (column_ff != COL_SAT) begin
            column_in = column_ff + 1'b1;
         end
      end
      position.line   = line_in[11:0];
      position.column = column_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         line_ff   <= '0;
         column_ff <= '0;
         cr_ff     <= 1'b0;
         lf_ff     <= 1'b0;
      end else if (step) begin
         line_ff   <= line_in;
         column_ff <= column_in;
         cr_ff     <= (text_byte == CH_CR);
         lf_ff     <= (text_byte == CH_LF);
      end
   end

endmodule

// ===== design/cts_skid.sv =====
// two-entry output buffer: output register plus skid register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cts_skid import cts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         pop;

   always_comb begin
      pop           = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_word_in  = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `ASSERT_IMPLY(skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff, "skid word without output word")
   `ASSERT_NEXT(stalled_push_kept, clock, reset, push && out_valid_ff && rsp_stall, skid_valid_ff, "word pushed behind a stalled output was lost")

endmodule

// ===== design/caseless_text_search_locator.sv =====
// top level of the caseless text search locator
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  text_byte, last_byte
//   rsp       out         rsp_valid / rsp_stall  found, match_offset, match_line, match_column
//   csr       in          csr_write_enable       csr_index, csr_write_data
//
// one text byte per cycle while req_stall is low; the window compare across the cell row is parallel
// a result word is registered in the output buffer before it appears on the rsp channel
// reset clears the text state, the registers and the output buffer
// req_stall rises only when both output buffer entries are full
`timescale 1ns / 1ps
`include "assert_macros.svh"

module caseless_text_search_locator import cts_pkg::*; #(
   parameter int PATTERN_MAX = 16,
   parameter int TEXT_MAX    = 65536,
   parameter int LINES_MAX   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [15:0] rsp_match_offset,
   output logic [11:0] rsp_match_line,
   output logic [15:0] rsp_match_column,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int CNT_W  = $clog2(TEXT_MAX + 1);
   localparam int CMP_W  = ((CNT_W > 16) ? CNT_W : 16) + 1;
   localparam int PM_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

   logic [63:0] pat_low_ff, pat_high_ff;
   logic [4:0]  pat_len_ff;
   logic [15:0] search_start_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             reported_ff, reported_in;

   logic             accept, step, first, in_range;
   logic [4:0]       len;
   logic [7:0]       pat_fold [REG_BYTES];
   position_type     position;
   cell_word_type    chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_hits;
   cell_word_type    sel_word;
   logic [CMP_W-1:0] have, need, start;
   logic             hit, push;
   rsp_word_type     push_word, rsp_word;
   logic             buf_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff      <= '0;
         pat_high_ff     <= '0;
         pat_len_ff      <= '0;
         search_start_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAT_LOW:      pat_low_ff      <= csr_write_data;
            CSR_PAT_HIGH:     pat_high_ff     <= csr_write_data;
            CSR_PAT_LEN:      pat_len_ff      <= csr_write_data[4:0];
            CSR_SEARCH_START: search_start_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < REG_BYTES; j++) begin
         if (j < 8) begin
            pat_fold[j] = fold(pat_low_ff[8*j +: 8]);
         end else begin
            pat_fold[j] = fold(pat_high_ff[8*(j-8) +: 8]);
         end
      end
      len = (pat_len_ff > 5'(PM_CAP)) ? 5'(PM_CAP) : pat_len_ff;
   end

   assign accept   = req_valid && !req_stall;
   assign in_range = count_ff < CNT_W'(TEXT_MAX);
   assign step     = accept && in_range;
   assign first    = (count_ff == '0);

   cts_position #(
      .LINES_MAX(LINES_MAX)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .first     (first),
      .clear     (accept && req_last_byte),
      .text_byte (req_text_byte),
      .position  (position)
   );

   assign chain[0] = '{text_byte: fold(req_text_byte), line: position.line,
                       column: position.column};

   // row of window cells, newest byte in cell 0
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic       active;
      logic [7:0] expected;

      always_comb begin
         active   = (k < int'(len));
         expected = '0;
         for (int j = 0; j < REG_BYTES; j++) begin
            if (j + k + 1 == int'(len)) begin
               expected = pat_fold[j];
            end
         end
      end

      if (k < PATTERN_MAX - 1) begin : g_mid
         cts_cell u_cell (
            .clock    (clock),
            .shift_en (step),
            .in_word  (chain[k]),
            .active   (active),
            .expected (expected),
            .out_word (chain[k+1]),
            .hit      (cell_hits[k])
         );
      end else begin : g_end
         cts_cell u_cell (
            .clock    (clock),
            .shift_en (step),
            .in_word  (chain[k]),
            .active   (active),
            .expected (expected),
            .out_word (),
            .hit      (cell_hits[k])
         );
      end
   end

   // position of the oldest byte in the match sits at the input of cell len-1
   always_comb begin
      sel_word = chain[0];
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (k + 1 == int'(len)) begin
            sel_word = chain[k];
         end
      end
   end

   always_comb begin
      have  = CMP_W'(count_ff) + 1'b1;
      need  = CMP_W'(len) + CMP_W'(search_start_ff);
      start = have - CMP_W'(len);
      hit   = step && !reported_ff && (len != '0) && (have >= need) && (&cell_hits);
      push  = hit || (accept && req_last_byte && !reported_ff);
      if (hit) begin
         push_word = '{found: 1'b1, match_offset: start[15:0],
                       match_line: sel_word.line, match_column: sel_word.column};
      end else begin
         push_word = '0;
      end
   end

   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff || hit;
      if (step) begin
         count_in = count_ff + 1'b1;
      end
      if (accept && req_last_byte) begin
         count_in    = '0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   cts_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign req_stall        = buf_full;
   assign rsp_found        = rsp_word.found;
   assign rsp_match_offset = rsp_word.match_offset;
   assign rsp_match_line   = rsp_word.match_line;
   assign rsp_match_column = rsp_word.match_column;

   `ASSERT_IMPLY(one_report_per_text, clock, reset, reported_ff, !push, "second word for one text")
   `ASSERT_NEXT(text_end_clears, clock, reset, accept && req_last_byte, count_ff == '0 && !reported_ff, "text state survived the last byte")

endmodule
